>>> design/mwo_pkg.sv
// Shared constants, types and the sine table generator for the waveform oscillator.
package mwo_pkg;

  localparam int unsigned PhaseBitsDef    = 32;
  localparam int unsigned SineAddrBitsDef = 10;
  localparam int unsigned StepW           = 32;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned LevelW          = 15;

  localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SINE     = 2'd3
  } wave_t;

  // Per-sample shaping result handed from the shaper to the output stage
  typedef struct packed {
    logic              use_sine;
    logic              negate;
    logic [LevelW-1:0] level;
  } shape_t;

  localparam longint unsigned Q30One    = 64'd1 << 30;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned SineDenom [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Quarter-wave sine entry in Q15, Q30 Taylor series; evaluated at elaboration only
  function automatic logic [LevelW-1:0] sine_entry(int unsigned idx, int unsigned addr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned d;
    longint unsigned s;
    x = (64'(idx) * HalfPiQ30) >> addr_bits;
    x2 = (x * x) >> 30;
    t = Q30One;
    for (int k = 0; k < 5; k++) begin
      d = ((x2 * t) >> 30) / SineDenom[k];
      t = (d >= Q30One) ? 64'd0 : Q30One - d;
    end
    s = (x * t) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[LevelW-1:0];
  endfunction

endpackage

>>> design/mwo_if.sv
// Valid/ready channel interfaces for the oscillator's input and result streams.
interface mwo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] phase_step;
  logic [31:0] pulse_width;

  modport source (output valid, output phase_step, output pulse_width, input ready);
  modport sink   (input valid, input phase_step, input pulse_width, output ready);
endinterface

interface mwo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> design/mwo_phase_acc.sv
// Phase accumulator: holds the running phase and presents its top 32 bits (zero-padded when narrower).
module mwo_phase_acc #(
  parameter int unsigned PHASE_BITS = mwo_pkg::PhaseBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [31:0] phase_step,
  output logic [31:0] p32
);

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [PHASE_BITS-1:0] step_al;

  generate
    if (PHASE_BITS > 32) begin : g_wide
      assign p32     = phase_r[PHASE_BITS-1 -: 32];
      assign step_al = {phase_step, {(PHASE_BITS-32){1'b0}}};
    end else if (PHASE_BITS == 32) begin : g_exact
      assign p32     = phase_r;
      assign step_al = phase_step;
    end else begin : g_narrow
      assign p32     = {phase_r, {(32-PHASE_BITS){1'b0}}};
      assign step_al = phase_step[31 -: PHASE_BITS];
    end
  endgenerate

  // wrap modulo one full phase turn
  assign phase_nxt = phase_r + step_al;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> design/mwo_shaper.sv
// Waveform shaper: saw, square and triangle levels plus sine table address and sign.
module mwo_shaper #(
  parameter int unsigned SINE_ADDR_BITS = mwo_pkg::SineAddrBitsDef
) (
  input  mwo_pkg::wave_t        wave,
  input  logic [31:0]           p32,
  input  logic [31:0]           pulse_width,
  output mwo_pkg::shape_t       shape,
  output logic [SINE_ADDR_BITS:0] rom_addr
);

  localparam logic [SINE_ADDR_BITS:0] RomN = {1'b1, {SINE_ADDR_BITS{1'b0}}};

  logic [31:0]                  neg_p;
  logic [14:0]                  saw_lvl;
  logic [14:0]                  sq_lvl;
  logic [14:0]                  tri_lvl;
  logic [15:0]                  h;
  logic [15:0]                  tri_diff;
  logic [SINE_ADDR_BITS-1:0]    r;

  assign neg_p   = ~p32 + 32'd1;
  // phase zero gives 1.0, held at full scale
  assign saw_lvl = (p32 == 32'd0) ? mwo_pkg::LevelMax : neg_p[31:17];
  assign sq_lvl  = (p32 < pulse_width) ? mwo_pkg::LevelMax : 15'd0;

  assign h = p32[31:16];
  always_comb begin
    tri_diff = 16'd0;
    if (p32[31:30] == 2'b00) begin
      tri_lvl = 15'(16'd16384 + h);
    end else if (h >= 16'd49152) begin
      tri_lvl = 15'(h - 16'd49152);
    end else begin
      tri_diff = 16'd49152 - h;
      tri_lvl  = tri_diff[15] ? mwo_pkg::LevelMax : tri_diff[14:0];
    end
  end

  // mirror the index in odd quadrants, negate in the second half of the period
  assign r        = p32[29 -: SINE_ADDR_BITS];
  assign rom_addr = p32[30] ? (RomN - {1'b0, r}) : {1'b0, r};

  always_comb begin
    shape.use_sine = 1'b0;
    shape.negate   = p32[31];
    case (wave)
      mwo_pkg::WAVE_SAW:      shape.level = saw_lvl;
      mwo_pkg::WAVE_SQUARE:   shape.level = sq_lvl;
      mwo_pkg::WAVE_TRIANGLE: shape.level = tri_lvl;
      mwo_pkg::WAVE_SINE: begin
        shape.level    = 15'd0;
        shape.use_sine = 1'b1;
      end
      default:                shape.level = saw_lvl;
    endcase
  end

endmodule

>>> design/mwo_sine_rom.sv
// Quarter-wave sine table with registered read.
module mwo_sine_rom #(
  parameter int unsigned SINE_ADDR_BITS = mwo_pkg::SineAddrBitsDef
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [SINE_ADDR_BITS:0]   rd_addr,
  output logic [14:0]               rd_data
);

  localparam int unsigned RomDepth = (1 << SINE_ADDR_BITS) + 1;

  logic [14:0] rom_tbl [RomDepth];
  logic [14:0] rd_data_r;

  generate
    for (genvar g = 0; g < RomDepth; g++) begin : g_tbl
      assign rom_tbl[g] = mwo_pkg::sine_entry(g, SINE_ADDR_BITS);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_tbl[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/multi_waveform_phase_oscillator_core.sv
// Top level of the multi-waveform phase oscillator.
//
// Usage:
//   in_ch  : valid/ready stream; each transfer carries phase_step (0.32 fraction of
//            a cycle) and pulse_width (0.32 duty threshold for the square wave).
//   out_ch : valid/ready stream; one transfer per input transfer, carrying a
//            signed Q1.15 sample taken from the phase before that input advanced it.
//   cfg_we / cfg_wdata : write wave_select (0 saw, 1 square, 2 triangle, 3 sine);
//            change it only while no transfer is in flight.
// Pipeline: after its input transfer a sample passes the input register, the sine
//   table read register and the output register, in that order.
// Throughput: one transfer per cycle while out_ch.ready stays high; the single
//   phase add is the only loop; the sine table gives one registered read per cycle.
// Reset (rst_n low, synchronous): phase cleared to zero, wave_select to saw,
//   all pipeline stages emptied. The sine table is constant and needs no sweep.
// Stall: when out_ch.ready is low the output register holds its sample; earlier
//   stages keep filling empty slots and in_ch.ready drops once all are full.
module multi_waveform_phase_oscillator_core #(
  parameter int unsigned PHASE_BITS     = mwo_pkg::PhaseBitsDef,
  parameter int unsigned SINE_ADDR_BITS = mwo_pkg::SineAddrBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  mwo_in_if.sink          in_ch,
  mwo_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata
);

  mwo_pkg::wave_t            wave_select_r;

  logic                      en1;
  logic                      en2;
  logic                      en_o;
  logic                      accept;

  logic [31:0]               p32;
  logic                      s1_valid_r;
  logic [31:0]               s1_p32_r;
  logic [31:0]               s1_pw_r;

  mwo_pkg::shape_t           shape;
  logic [SINE_ADDR_BITS:0]   rom_addr;
  logic                      s2_valid_r;
  mwo_pkg::shape_t           s2_shape_r;
  logic [14:0]               rom_data;

  logic                      out_valid_r;
  logic signed [15:0]        out_sample_r;
  logic signed [15:0]        sample_nxt;
  logic signed [15:0]        rom_val;

  // Each stage advances when it is empty or the stage after it advances
  assign en_o   = !out_valid_r || out_ch.ready;
  assign en2    = !s2_valid_r || en_o;
  assign en1    = !s1_valid_r || en2;
  assign accept = in_ch.valid && en1;

  assign in_ch.ready = en1;

  // Phase is sampled for this transfer, then advanced by its step
  mwo_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (accept),
    .phase_step (in_ch.phase_step),
    .p32        (p32)
  );

  mwo_shaper #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_shaper (
    .wave        (wave_select_r),
    .p32         (s1_p32_r),
    .pulse_width (s1_pw_r),
    .shape       (shape),
    .rom_addr    (rom_addr)
  );

  // Table read registers alongside the shaped level in stage two
  mwo_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (en2),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Apply the quadrant sign to the table value, or pass the level through
  assign rom_val    = {1'b0, rom_data};
  assign sample_nxt = s2_shape_r.use_sine ? (s2_shape_r.negate ? -rom_val : rom_val)
                                          : {1'b0, s2_shape_r.level};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      wave_select_r <= mwo_pkg::WAVE_SAW;
    end else begin
      if (en1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_o) begin
        out_valid_r <= s2_valid_r;
      end
      if (cfg_we) begin
        wave_select_r <= mwo_pkg::wave_t'(cfg_wdata);
      end
    end
  end

  // Payload: hold while the downstream stage is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_p32_r <= p32;
      s1_pw_r  <= in_ch.pulse_width;
    end
    if (en2) begin
      s2_shape_r <= shape;
    end
    if (en_o) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

endmodule

>>> design/mwo_checker.sv
// Port-level assertions for the oscillator, bound to the top level.
module mwo_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample
);

  // Reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A drained or draining output never back-pressures the input
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output is free");

  // A stalled sample holds until its transfer
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("stalled sample changed");

  // Every waveform stays within plus or minus full scale
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample != 16'sh8000))
    else $error("sample below negative full scale");

endmodule

bind multi_waveform_phase_oscillator_core mwo_checker u_mwo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample)
);
